@@ hw/rtl/fbc_pkg.sv @@
// Shared constants for the frustum box cull block: action codes and the
// corner pattern of the six view volume planes. No dependencies.
`timescale 1ns / 1ps

package fbc_pkg;

  localparam logic [1:0] ACT_CORNER = 2'd0;
  localparam logic [1:0] ACT_MATRIX = 2'd1;
  localparam logic [1:0] ACT_TEST   = 2'd2;

  localparam int unsigned NUM_CORNERS = 8;
  localparam int unsigned NUM_ROWS    = 4;
  localparam int unsigned NUM_PLANES  = 6;

  localparam logic [2:0] LAST_CORNER = 3'd7;
  localparam logic [2:0] LAST_PLANE  = 3'd5;

  // plane origin corner
  function automatic logic [2:0] plane_o(input logic [2:0] p);
    logic [2:0] r;
    unique case (p)
      3'd0, 3'd1, 3'd3: r = 3'd0;
      3'd2:             r = 3'd1;
      3'd4:             r = 3'd3;
      3'd5:             r = 3'd4;
      default:          r = 3'd0;
    endcase
    return r;
  endfunction

  // first edge end corner
  function automatic logic [2:0] plane_a(input logic [2:0] p);
    logic [2:0] r;
    unique case (p)
      3'd0, 3'd2: r = 3'd2;
      3'd1:       r = 3'd4;
      3'd3:       r = 3'd1;
      3'd4:       r = 3'd7;
      3'd5:       r = 3'd5;
      default:    r = 3'd0;
    endcase
    return r;
  endfunction

  // end corner of the other edge
  function automatic logic [2:0] plane_b(input logic [2:0] p);
    logic [2:0] r;
    unique case (p)
      3'd0:    r = 3'd1;
      3'd1:    r = 3'd3;
      3'd2:    r = 3'd5;
      3'd3:    r = 3'd4;
      3'd4:    r = 3'd2;
      3'd5:    r = 3'd7;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/fbc_ram.sv @@
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module fbc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/frustum_box_cull_top.sv @@
// Frustum box cull top level: corner, matrix and normal stores in RAMs,
// one shared multiplier stepped by a sequencer. Uses fbc_pkg and fbc_ram.
//
//  channel  | dir | tdata                                   | tuser
//  s_axis   | in  | vec_x,vec_y,vec_z,high_x,high_y,high_z  | action, slot
//  m_axis   | out | outside                                 | not_ready
//
// Loads of corners 0..6 and matrix rows are written straight to the RAMs.
// Loading corner 7 also builds the plane normals: six planes of twelve
// steps on the single multiplier. A box test transforms the box, then
// checks the planes (24 partial products each), stopping when one culls.
// Reset clears the ready mark; stores hold nothing until written.
// A finished result waits in the output register; the next transfer is
// taken meanwhile, and a test result stalls only if that register is full.
`timescale 1ns / 1ps

module frustum_box_cull_top
  import fbc_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // vec_x, vec_y, vec_z, high_x, high_y, high_z
  input  logic [191:0] s_axis_tdata,
  // action, slot
  input  logic [4:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // outside, zero fill
  output logic [7:0]   m_axis_tdata,
  // not_ready
  output logic [0:0]   m_axis_tuser
);

  localparam int unsigned CW  = COORD_WIDTH;
  localparam int unsigned NW  = (2 * CW + 1 > 64) ? 64 : 2 * CW + 1;
  localparam int unsigned HW  = NW - CW;
  localparam int unsigned BW  = HW + 1;
  localparam int unsigned PW  = CW + BW;
  localparam int unsigned AW  = CW + NW + 4;
  localparam int unsigned NAW = 2 * CW + 2;
  localparam int unsigned OAW = 2 * CW + 2;
  localparam int unsigned WS  = 2 * CW + 4;

  localparam logic signed [WS-1:0] SMAX = {{(WS-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [WS-1:0] SMIN = {{(WS-CW+1){1'b1}}, {(CW-1){1'b0}}};

  typedef enum logic [2:0] {
    S_IDLE, S_NRM, S_XFM, S_PLN, S_PMUL, S_PCHK, S_DONE
  } state_e;

  typedef enum logic [2:0] {
    OP_NONE, OP_NRM, OP_EDGE, OP_ORG, OP_PLN
  } op_e;

  typedef struct packed {
    op_e        kind;
    logic [1:0] sel;
    logic [1:0] row;
    logic       neg;
    logic       hi;
    logic       first;
    logic       last;
    logic       grp0;
  } op_t;

  function automatic logic signed [CW-1:0] sat_cw(input logic signed [WS-1:0] x);
    logic signed [CW-1:0] r;
    if (x > SMAX) begin
      r = SMAX[CW-1:0];
    end else if (x < SMIN) begin
      r = SMIN[CW-1:0];
    end else begin
      r = x[CW-1:0];
    end
    return r;
  endfunction

  state_e     state_q;
  logic [3:0] step_q;
  logic [2:0] plane_q;
  logic [1:0] row_q;
  logic [1:0] g_q;
  logic [1:0] c_q;
  logic       h_q;
  logic       ready_q;
  logic       m_valid_q;
  logic       m_outside_q;
  logic       m_nready_q;
  logic       res_outside_q;
  logic       res_nready_q;
  op_t        op_q;
  op_t        op_d;

  logic        s_acc;
  logic [1:0]  act;
  logic [2:0]  slot;
  logic signed [CW-1:0] in_v [3];
  logic signed [CW-1:0] in_h [3];

  logic          c_we;
  logic [2:0]    c_raddr;
  logic [3*CW-1:0] c_rdata;
  logic          m_we;
  logic [1:0]    m_raddr;
  logic [3*CW-1:0] m_rdata;
  logic          n_we;
  logic [3*NW-1:0] n_wdata;
  logic [3*NW-1:0] n_rdata;

  logic signed [CW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [PW-1:0] prod_q;
  logic signed [AW-1:0] prod_w;
  logic signed [AW-1:0] shr_w;
  logic signed [AW-1:0] term_w;
  logic signed [AW-1:0] tsum_w;

  logic signed [CW-1:0]  co_q [3];
  logic signed [CW-1:0]  ad_q [3];
  logic signed [CW-1:0]  bd_q [3];
  logic signed [NAW-1:0] nacc_q [3];
  logic signed [CW-1:0]  mrow_q [3];
  logic signed [CW-1:0]  edge_q [3][3];
  logic signed [OAW-1:0] oacc_q [3];
  logic signed [CW-1:0]  orgf_q [3];
  logic signed [CW-1:0]  low_q [3];
  logic signed [CW-1:0]  dlt_q [3];
  logic [3*NW-1:0]       nrm_q;
  logic signed [CW-1:0]  do_q [3];
  logic signed [AW-1:0]  tacc_q;
  logic signed [AW-1:0]  acc_q;
  logic                  acc_pos;

  assign act   = s_axis_tuser[1:0];
  assign slot  = s_axis_tuser[4:2];
  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_v[i] = sat_cw(WS'($signed(s_axis_tdata[32*i +: 32])));
      in_h[i] = sat_cw(WS'($signed(s_axis_tdata[96 + 32*i +: 32])));
    end
  end

  fbc_ram #(.WIDTH(3 * CW), .DEPTH(NUM_CORNERS)) u_corner_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (slot),
    .wdata_i ({in_v[2], in_v[1], in_v[0]}),
    .raddr_i (c_raddr),
    .rdata_o (c_rdata)
  );

  fbc_ram #(.WIDTH(3 * CW), .DEPTH(NUM_ROWS)) u_matrix_ram (
    .clk_i   (clk_i),
    .we_i    (m_we),
    .waddr_i (slot[1:0]),
    .wdata_i ({in_v[2], in_v[1], in_v[0]}),
    .raddr_i (m_raddr),
    .rdata_o (m_rdata)
  );

  fbc_ram #(.WIDTH(3 * NW), .DEPTH(NUM_PLANES)) u_normal_ram (
    .clk_i   (clk_i),
    .we_i    (n_we),
    .waddr_i (plane_q),
    .wdata_i (n_wdata),
    .raddr_i (plane_q),
    .rdata_o (n_rdata)
  );

  assign n_wdata = {nacc_q[2][NW-1:0], nacc_q[1][NW-1:0], nacc_q[0][NW-1:0]};

  // operand selection and write strobes
  always_comb begin
    logic [NW-1:0]        ncomp;
    logic signed [CW-1:0] mc;
    ncomp   = '0;
    mc      = '0;
    mul_a   = '0;
    mul_b   = '0;
    op_d    = '0;
    op_d.kind = OP_NONE;
    c_we    = 1'b0;
    m_we    = 1'b0;
    n_we    = 1'b0;
    c_raddr = plane_o(plane_q);
    m_raddr = row_q;
    unique case (state_q)
      S_IDLE: begin
        c_we = s_acc && (act == ACT_CORNER);
        m_we = s_acc && (act == ACT_MATRIX) && !slot[2];
      end
      S_NRM: begin
        priority case (step_q)
          4'd1: c_raddr = plane_a(plane_q);
          4'd2: c_raddr = plane_b(plane_q);
          default: c_raddr = plane_o(plane_q);
        endcase
        op_d.kind = OP_NRM;
        unique case (step_q)
          4'd4: begin mul_a = ad_q[1]; mul_b = BW'(bd_q[2]); op_d.sel = 2'd0; end
          4'd5: begin mul_a = ad_q[2]; mul_b = BW'(bd_q[1]); op_d.sel = 2'd0;
                      op_d.neg = 1'b1; end
          4'd6: begin mul_a = ad_q[2]; mul_b = BW'(bd_q[0]); op_d.sel = 2'd1; end
          4'd7: begin mul_a = ad_q[0]; mul_b = BW'(bd_q[2]); op_d.sel = 2'd1;
                      op_d.neg = 1'b1; end
          4'd8: begin mul_a = ad_q[0]; mul_b = BW'(bd_q[1]); op_d.sel = 2'd2; end
          4'd9: begin mul_a = ad_q[1]; mul_b = BW'(bd_q[0]); op_d.sel = 2'd2;
                      op_d.neg = 1'b1; end
          default: op_d.kind = OP_NONE;
        endcase
        n_we = (step_q == 4'd11);
      end
      S_XFM: begin
        op_d.row   = row_q;
        op_d.first = (row_q == 2'd0);
        if (row_q != 2'd3 && step_q >= 4'd2 && step_q <= 4'd4) begin
          op_d.kind = OP_EDGE;
          op_d.sel  = 2'(step_q - 4'd2);
          mul_a     = dlt_q[row_q];
          mc        = mrow_q[op_d.sel];
          mul_b     = BW'(mc);
        end else if (row_q != 2'd3 && step_q >= 4'd5 && step_q <= 4'd7) begin
          op_d.kind = OP_ORG;
          op_d.sel  = 2'(step_q - 4'd5);
          mul_a     = low_q[row_q];
          mc        = mrow_q[op_d.sel];
          mul_b     = BW'(mc);
        end
      end
      S_PMUL: begin
        ncomp      = nrm_q[NW*c_q +: NW];
        op_d.kind  = OP_PLN;
        op_d.hi    = h_q;
        op_d.first = (c_q == 2'd0) && !h_q;
        op_d.last  = (c_q == 2'd2) && h_q;
        op_d.grp0  = (g_q == 2'd0);
        mul_a      = (g_q == 2'd0) ? do_q[c_q] : edge_q[g_q - 2'd1][c_q];
        mul_b      = h_q ? $signed({ncomp[NW-1], ncomp[NW-1:CW]})
                         : $signed({{(BW-CW){1'b0}}, ncomp[CW-1:0]});
      end
      S_PLN, S_PCHK, S_DONE: ;
      default: ;
    endcase
  end

  assign prod_w = AW'(prod_q);
  assign shr_w  = prod_w >>> FRAC_BITS;
  assign term_w = op_q.hi ? (prod_w <<< CW) : prod_w;
  assign tsum_w = (op_q.first ? AW'(0) : tacc_q) + term_w;
  assign acc_pos = !acc_q[AW-1] && (acc_q != '0);

  // datapath: no reset
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (s_acc) begin
      for (int i = 0; i < 3; i++) begin
        low_q[i] <= in_v[i];
        dlt_q[i] <= sat_cw(WS'(in_h[i]) - WS'(in_v[i]));
      end
    end
    if (state_q == S_NRM) begin
      for (int i = 0; i < 3; i++) begin
        if (step_q == 4'd1) begin
          co_q[i] <= $signed(c_rdata[CW*i +: CW]);
        end
        if (step_q == 4'd2) begin
          ad_q[i] <= sat_cw(WS'($signed(c_rdata[CW*i +: CW])) - WS'(co_q[i]));
        end
        if (step_q == 4'd3) begin
          bd_q[i] <= sat_cw(WS'($signed(c_rdata[CW*i +: CW])) - WS'(co_q[i]));
        end
      end
    end
    if (state_q == S_XFM) begin
      for (int i = 0; i < 3; i++) begin
        if (step_q == 4'd1 && row_q != 2'd3) begin
          mrow_q[i] <= $signed(m_rdata[CW*i +: CW]);
        end
        if (step_q == 4'd1 && row_q == 2'd3) begin
          oacc_q[i] <= oacc_q[i] + OAW'($signed(m_rdata[CW*i +: CW]));
        end
        if (step_q == 4'd2 && row_q == 2'd3) begin
          orgf_q[i] <= sat_cw((i == 2) ? -WS'(oacc_q[i]) : WS'(oacc_q[i]));
        end
      end
    end
    if (state_q == S_PLN && step_q == 4'd1) begin
      nrm_q <= n_rdata;
      for (int i = 0; i < 3; i++) begin
        do_q[i] <= sat_cw(WS'(orgf_q[i]) - WS'($signed(c_rdata[CW*i +: CW])));
      end
    end
    unique case (op_q.kind)
      OP_NRM: begin
        nacc_q[op_q.sel] <= op_q.neg ? nacc_q[op_q.sel] - NAW'(prod_w) : NAW'(prod_w);
      end
      OP_EDGE: begin
        edge_q[op_q.row][op_q.sel] <=
          sat_cw((op_q.sel == 2'd2) ? -WS'(shr_w) : WS'(shr_w));
      end
      OP_ORG: begin
        oacc_q[op_q.sel] <= (op_q.first ? OAW'(0) : oacc_q[op_q.sel]) + OAW'(shr_w);
      end
      OP_PLN: begin
        tacc_q <= tsum_w;
        if (op_q.last) begin
          if (op_q.grp0) begin
            acc_q <= tsum_w;
          end else if (tsum_w[AW-1]) begin
            acc_q <= acc_q + tsum_w;
          end
        end
      end
      OP_NONE: ;
      default: ;
    endcase
  end

  // sequencer, ready mark and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      step_q        <= '0;
      plane_q       <= '0;
      row_q         <= '0;
      g_q           <= '0;
      c_q           <= '0;
      h_q           <= 1'b0;
      ready_q       <= 1'b0;
      m_valid_q     <= 1'b0;
      m_outside_q   <= 1'b0;
      m_nready_q    <= 1'b0;
      res_outside_q <= 1'b0;
      res_nready_q  <= 1'b0;
      op_q          <= '0;
    end else begin
      op_q <= op_d;
      if (m_valid_q && m_axis_tready && state_q != S_DONE) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_acc) begin
            if (act == ACT_CORNER) begin
              if (slot == 3'd0) begin
                ready_q <= 1'b0;
              end
              if (slot == LAST_CORNER) begin
                state_q <= S_NRM;
                plane_q <= '0;
                step_q  <= '0;
              end
            end else if (act == ACT_TEST) begin
              if (!ready_q) begin
                res_outside_q <= 1'b0;
                res_nready_q  <= 1'b1;
                state_q       <= S_DONE;
              end else begin
                state_q <= S_XFM;
                row_q   <= '0;
                step_q  <= '0;
              end
            end
          end
        end
        S_NRM: begin
          if (step_q == 4'd11) begin
            step_q <= '0;
            if (plane_q == LAST_PLANE) begin
              ready_q <= 1'b1;
              state_q <= S_IDLE;
            end else begin
              plane_q <= plane_q + 3'd1;
            end
          end else begin
            step_q <= step_q + 4'd1;
          end
        end
        S_XFM: begin
          if (row_q == 2'd3) begin
            if (step_q == 4'd2) begin
              state_q <= S_PLN;
              plane_q <= '0;
              step_q  <= '0;
            end else begin
              step_q <= step_q + 4'd1;
            end
          end else if (step_q == 4'd7) begin
            row_q  <= row_q + 2'd1;
            step_q <= '0;
          end else begin
            step_q <= step_q + 4'd1;
          end
        end
        S_PLN: begin
          if (step_q == 4'd1) begin
            state_q <= S_PMUL;
            step_q  <= '0;
            g_q     <= '0;
            c_q     <= '0;
            h_q     <= 1'b0;
          end else begin
            step_q <= step_q + 4'd1;
          end
        end
        S_PMUL: begin
          h_q <= !h_q;
          if (h_q) begin
            if (c_q == 2'd2) begin
              c_q <= '0;
              if (g_q == 2'd3) begin
                state_q <= S_PCHK;
                step_q  <= '0;
              end else begin
                g_q <= g_q + 2'd1;
              end
            end else begin
              c_q <= c_q + 2'd1;
            end
          end
        end
        S_PCHK: begin
          if (step_q == 4'd0) begin
            step_q <= 4'd1;
          end else if (acc_pos) begin
            res_outside_q <= 1'b1;
            res_nready_q  <= 1'b0;
            state_q       <= S_DONE;
          end else if (plane_q == LAST_PLANE) begin
            res_outside_q <= 1'b0;
            res_nready_q  <= 1'b0;
            state_q       <= S_DONE;
          end else begin
            plane_q <= plane_q + 3'd1;
            step_q  <= '0;
            state_q <= S_PLN;
          end
        end
        S_DONE: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q   <= 1'b1;
            m_outside_q <= res_outside_q;
            m_nready_q  <= res_nready_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'd0, m_outside_q};
  assign m_axis_tuser  = m_nready_q;

endmodule
